// ----- design/fc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fc_pkg;

    localparam int TAPS_DEFAULT  = 256;

    localparam int ACTION_W      = 2;
    localparam int TAP_INDEX_W   = 8;
    localparam int COEF_W        = 16;
    localparam int SAMPLE_W      = 16;
    localparam int PROD_W        = COEF_W + SAMPLE_W;
    localparam int ACC_W         = 40;
    localparam int NUM_TAPS_W    = 9;
    localparam int IN_DATA_W     = TAP_INDEX_W + COEF_W + SAMPLE_W;
    localparam int OUT_DATA_W    = ACC_W;

    localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET = 9'd256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MAC,
        ST_DRAIN
    } seq_state_t;

    // sequencer to multiply-accumulate pipeline
    typedef struct packed {
        logic start;  // clear the accumulator for a new request
        logic rd;     // a tap pair is read from both stores this cycle
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- design/fc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fc_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/fc_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fc_mac
    import fc_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mac_ctl_t                   ctl,
    input  wire logic signed [COEF_W-1:0]   coef_q,
    input  wire logic signed [SAMPLE_W-1:0] hist_q,
    output logic                            busy,
    output logic signed [ACC_W-1:0]         acc
);

    logic                     dv_reg;
    logic                     pv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // read data lands in the cycle after the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else begin
            dv_reg <= ctl.rd;
            pv_reg <= dv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef_q * hist_q;
    end

    // wrap modulo 2^40
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = dv_reg | pv_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ----- design/fc_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fc_seq
    import fc_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT,
    parameter int AW   = 8,
    parameter int CW   = 9
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [ACTION_W-1:0]      action,
    input  wire logic [TAP_INDEX_W-1:0]   tap_index,
    input  wire logic [COEF_W-1:0]        tap_value,
    input  wire logic [SAMPLE_W-1:0]      sample,
    input  wire logic [NUM_TAPS_W-1:0]    num_taps,
    output logic                          coef_we,
    output logic [AW-1:0]                 coef_waddr,
    output logic [COEF_W-1:0]             coef_wdata,
    output logic [AW-1:0]                 coef_raddr,
    output logic                          hist_we,
    output logic [AW-1:0]                 hist_waddr,
    output logic [SAMPLE_W-1:0]           hist_wdata,
    output logic [AW-1:0]                 hist_raddr,
    output mac_ctl_t                      ctl,
    input  wire logic                     mac_busy,
    input  wire logic signed [ACC_W-1:0]  acc,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata
);

    localparam int LW = (CW > NUM_TAPS_W) ? CW : NUM_TAPS_W;

    seq_state_t            state_reg, state_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         haddr_reg, haddr_next;
    logic                  mv_reg, mv_next;
    logic [OUT_DATA_W-1:0] md_reg, md_next;

    logic [AW-1:0]         ptr_dec;
    logic [CW-1:0]         n_eff;
    logic                  tap_ok;
    logic                  k_last_sweep;
    logic                  out_free;

    assign ptr_dec      = (ptr_reg == '0) ? AW'(TAPS - 1) : ptr_reg - 1'b1;
    assign n_eff        = (LW'(num_taps) > LW'(TAPS)) ? CW'(TAPS) : CW'(num_taps);
    assign tap_ok       = LW'(tap_index) < LW'(TAPS);
    assign k_last_sweep = k_reg == CW'(TAPS - 1);
    assign out_free     = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            k_reg     <= '0;
            n_reg     <= '0;
            ptr_reg   <= '0;
            haddr_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            ptr_reg   <= ptr_next;
            haddr_reg <= haddr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        ptr_next   = ptr_reg;
        haddr_next = haddr_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        s_tready   = 1'b0;
        coef_we    = 1'b0;
        coef_waddr = AW'(tap_index);
        coef_wdata = tap_value;
        hist_we    = 1'b0;
        hist_waddr = ptr_dec;
        hist_wdata = sample;
        ctl        = '0;

        unique case (state_reg)
            ST_INIT: begin
                coef_we    = 1'b1;
                coef_waddr = k_reg[AW-1:0];
                coef_wdata = '0;
                hist_we    = 1'b1;
                hist_waddr = k_reg[AW-1:0];
                hist_wdata = '0;
                if (k_last_sweep) begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (action)
                        ACT_LOAD: begin
                            coef_we = tap_ok;
                        end
                        ACT_PUSH: begin
                            hist_we    = 1'b1;
                            ptr_next   = ptr_dec;
                            haddr_next = ptr_dec;
                            k_next     = '0;
                            n_next     = n_eff;
                            ctl.start  = 1'b1;
                            state_next = (n_eff == '0) ? ST_DRAIN : ST_MAC;
                        end
                        ACT_CLEAR: begin
                            k_next     = '0;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = k_reg[AW-1:0];
                hist_wdata = '0;
                if (k_last_sweep) begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_MAC: begin
                ctl.rd     = 1'b1;
                k_next     = k_reg + 1'b1;
                haddr_next = (haddr_reg == AW'(TAPS - 1)) ? '0 : haddr_reg + 1'b1;
                if (CW'(k_reg + 1'b1) == n_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy && out_free) begin
                    mv_next    = 1'b1;
                    md_next    = acc;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign coef_raddr = k_reg[AW-1:0];
    assign hist_raddr = haddr_reg;
    assign m_tvalid   = mv_reg;
    assign m_tdata    = md_reg;

endmodule

`default_nettype wire

// ----- design/fir_convolution.sv -----
// Push request: the block walks n taps, n being num_taps capped at TAPS, then shows the
//   result; s_tready returns with it. A result left waiting on m_tready holds the next
//   back. One tap per cycle: one read port per store.
// Load request or ignored action code: s_tready stays high. Clear: history swept to zero.
// Reset (aresetn low, synchronous): both stores are swept to zero with s_tready low;
//   num_taps returns to 256 and configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module fir_convolution
    import fc_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // tap_index[7:0], tap_value, sample
    input  wire logic [ACTION_W-1:0]    s_tuser,   // action
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // acc_out
    // num_taps register
    input  wire logic                   cfg_wr_en,
    input  wire logic [NUM_TAPS_W-1:0]  cfg_wr_data
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1);

    // unpack the request payload
    logic [TAP_INDEX_W-1:0] tap_index;
    logic [COEF_W-1:0]      tap_value;
    logic [SAMPLE_W-1:0]    sample;

    assign tap_index = s_tdata[TAP_INDEX_W-1:0];
    assign tap_value = s_tdata[TAP_INDEX_W +: COEF_W];
    assign sample    = s_tdata[TAP_INDEX_W + COEF_W +: SAMPLE_W];

    // number of taps in use; a write takes effect from the next push
    logic [NUM_TAPS_W-1:0] num_taps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= NUM_TAPS_RESET;
        end else if (cfg_wr_en) begin
            num_taps_reg <= cfg_wr_data;
        end
    end

    // store ports
    logic                coef_we;
    logic [AW-1:0]       coef_waddr;
    logic [COEF_W-1:0]   coef_wdata;
    logic [AW-1:0]       coef_raddr;
    logic [COEF_W-1:0]   coef_q;
    logic                hist_we;
    logic [AW-1:0]       hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [AW-1:0]       hist_raddr;
    logic [SAMPLE_W-1:0] hist_q;

    mac_ctl_t                mac_ctl;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] mac_acc;

    // Sequencer: sweeps both stores on reset and the history on clear, writes coefficients,
    // advances the history head on a push and walks the taps one per cycle.
    fc_seq #(
        .TAPS (TAPS),
        .AW   (AW),
        .CW   (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (s_tuser),
        .tap_index  (tap_index),
        .tap_value  (tap_value),
        .sample     (sample),
        .num_taps   (num_taps_reg),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata),
        .coef_raddr (coef_raddr),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_raddr (hist_raddr),
        .ctl        (mac_ctl),
        .mac_busy   (mac_busy),
        .acc        (mac_acc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Coefficient store, indexed by tap number.
    fc_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (COEF_W)
    ) u_coef_ram (
        .clk   (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_q)
    );

    // History store as a circular buffer: the head points at the newest sample,
    // a push moves the head back one entry, so delay k sits k entries past it.
    // The new sample is written before the first tap read, so no forwarding.
    fc_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    // Multiply, register, accumulate at 40 bits.
    fc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef_q  (coef_q),
        .hist_q  (hist_q),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

endmodule

`default_nettype wire

// ----- design/fc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fc_checker
    import fc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [ACTION_W-1:0]   s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // reset starts the store sweep and drops any pending result
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("requests taken or result shown right after reset");

    // a push holds off further requests while its taps are walked
    a_push_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == ACT_PUSH) |=> !s_tready)
        else $error("request taken in the cycle after a push");

    // a load never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == ACT_LOAD && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared after a load");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind fir_convolution fc_checker u_fc_checker (.*);

`default_nettype wire

// ----- sim/fir_convolution_tb.sv -----
`timescale 1ns / 1ps

module fir_convolution_tb;
    import fc_pkg::*;

    localparam int TAPS = TAPS_DEFAULT;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    // a clear request holds the block while the history is swept, with no result to show for it
    localparam int SETTLE_CYCLES = TAPS + 16;
    // slowest gap: a full-window push under receiver stalls, or a settle pause
    localparam int WATCHDOG_CYCLES = 20 * (TAPS + 8);
    localparam int MAX_PRINTED = 100;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // tap_index, tap_value, sample (from bit 0 up)
    logic [ACTION_W-1:0]   s_tuser = '0;   // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // acc_out
    logic                  cfg_wr_en = 1'b0;
    logic [NUM_TAPS_W-1:0] cfg_wr_data = '0;

    // filter state as the block should hold it
    logic signed [COEF_W-1:0]   coef_store [TAPS];
    logic signed [SAMPLE_W-1:0] sample_line [TAPS];
    int                         taps_in_use;

    // accumulator values still owed by the block, oldest first
    logic [ACC_W-1:0] expected_acc [$];

    int idle_pct = 20;
    int mismatches = 0;
    int results_checked = 0;
    int n_loads = 0;
    int n_pushes = 0;
    int n_clears = 0;
    int n_ignored = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    fir_convolution #(
        .TAPS(TAPS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Advance the filter state by one accepted request; queue the sum a push owes.
    task automatic predict_request(input logic [ACTION_W-1:0] act,
                                   input logic [TAP_INDEX_W-1:0] idx,
                                   input logic [COEF_W-1:0] coef,
                                   input logic [SAMPLE_W-1:0] smp);
        longint acc;
        int     n;
        case (act)
            ACT_LOAD: begin
                if (idx < TAPS) begin
                    coef_store[idx] = coef;
                end
                n_loads++;
            end
            ACT_CLEAR: begin
                foreach (sample_line[k]) sample_line[k] = '0;
                n_clears++;
            end
            ACT_PUSH: begin
                // the whole line shifts, inactive positions included
                for (int k = TAPS - 1; k > 0; k--) begin
                    sample_line[k] = sample_line[k-1];
                end
                sample_line[0] = smp;
                n = (taps_in_use > TAPS) ? TAPS : taps_in_use;
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    acc += longint'(coef_store[k]) * longint'(sample_line[k]);
                end
                expected_acc.push_back(ACC_W'(acc));
                n_pushes++;
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    // Offer one request after a random gap; return at the edge it is accepted.
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [TAP_INDEX_W-1:0] idx,
                                input logic [COEF_W-1:0] coef,
                                input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {smp, coef, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(act, idx, coef, smp);
    endtask

    task automatic stream_idle();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_acc.size() != 0) @(posedge aclk);
    endtask

    // Write the tap count only with the block idle: drain, then let a clear finish.
    task automatic set_num_taps(input int value);
        stream_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= NUM_TAPS_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        taps_in_use = value;
        n_settings++;
    endtask

    // Full-scale values show up often so the widest products get exercised.
    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 16'h8000;
        if (r < 30) return 16'h7FFF;
        if (r < 35) return 16'h0000;
        return 16'($urandom);
    endfunction

    // Check every accepted result against the modelled accumulator.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_acc.size() == 0) begin
                report_mismatch($sformatf("unexpected result acc_out=%0d",
                                          $signed(m_tdata)));
            end else begin
                if (m_tdata[ACC_W-1:0] !== expected_acc[0]) begin
                    report_mismatch($sformatf("acc_out got %0d expected %0d",
                                              $signed(m_tdata[ACC_W-1:0]),
                                              $signed(expected_acc[0])));
                end
                void'(expected_acc.pop_front());
            end
        end
    end

    // Receiver stalls follow the same idle rate as the sender.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Drop the run if nothing moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout: no request or result moved for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_reset();
        foreach (coef_store[k]) coef_store[k] = '0;
        foreach (sample_line[k]) sample_line[k] = '0;
        taps_in_use = NUM_TAPS_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        // the tap store starts at zero, so the full default window sums to zero
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h7FFF);
    endtask

    task automatic test_directed();
        set_num_taps(2);
        send_request(ACT_LOAD, 8'd0, 16'h8000, 16'h0000);
        send_request(ACT_LOAD, 8'd1, 16'h8000, 16'h0000);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h8000);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h8000);
        // top tap index; lies outside the active window
        send_request(ACT_LOAD, 8'd255, 16'h7FFF, 16'h0000);
        // unused action code with every data bit set: no state change
        send_request(ACT_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(ACT_PUSH, 8'hFF, 16'hFFFF, 16'h0000);
        send_request(ACT_LOAD, 8'd1, 16'h7FFF, 16'hFFFF);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h7FFF);
        send_request(ACT_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h0001);
        // history keeps shifting past the active window
        set_num_taps(1);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'hFFFF);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h0005);
        set_num_taps(2);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h0007);
        // no taps in use sums nothing
        set_num_taps(0);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h7FFF);
        // counts above the store size saturate to the full window
        set_num_taps(511);
        send_request(ACT_LOAD, 8'd128, 16'h5555, 16'h0000);
        send_request(ACT_LOAD, 8'd127, 16'hAAAA, 16'h0000);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'h5555);
        send_request(ACT_PUSH, 8'd0, 16'h0000, 16'hAAAA);
    endtask

    // Mostly sample bursts, with coefficient reloads, clears and unused codes mixed in.
    task automatic run_random_phase(input int num_taps, input int items, input bit pauses);
        int count;
        int window;
        int r;
        int burst;
        logic [TAP_INDEX_W-1:0] idx;
        set_num_taps(num_taps);
        window = (num_taps > TAPS) ? TAPS : num_taps;
        if (window == 0) window = 8;
        count = 0;
        while (count < items) begin
            r = $urandom_range(99);
            if (r < 10) begin
                burst = $urandom_range((window < 8) ? window : 8, 1);
                repeat (burst) begin
                    if ($urandom_range(9) == 0) idx = 8'($urandom);
                    else idx = 8'($urandom_range(window - 1));
                    send_request(ACT_LOAD, idx, pick_value(), 16'($urandom));
                    count++;
                end
            end else if (r < 12) begin
                send_request(ACT_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
                count++;
            end else if (r < 15) begin
                send_request(ACT_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                burst = $urandom_range(12, 1);
                repeat (burst) begin
                    send_request(ACT_PUSH, 8'($urandom), 16'($urandom), pick_value());
                    count++;
                end
            end
            if (pauses && $urandom_range(9) == 0) begin
                // hold the stream until the block has handed back everything
                stream_idle();
                @(posedge aclk);
                wait_results_drained();
            end
        end
    endtask

    // Load every tap, then push a whole window so the oldest position contributes.
    task automatic test_full_window();
        set_num_taps(TAPS);
        for (int k = 0; k < TAPS; k++) begin
            send_request(ACT_LOAD, 8'(k), pick_value(), 16'($urandom));
        end
        repeat (TAPS + 4) begin
            send_request(ACT_PUSH, 8'($urandom), 16'($urandom), pick_value());
        end
    endtask

    task automatic test_random_mix();
        run_random_phase(3, 160, 1'b0);
        run_random_phase(16, 160, 1'b0);
        run_random_phase(1, 160, 1'b0);
        run_random_phase(47, 160, 1'b0);
        run_random_phase($urandom_range(32, 2), 160, 1'b0);
        run_random_phase(0, 80, 1'b0);
        run_random_phase(511, 100, 1'b0);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        run_random_phase(12, 200, 1'b0);
        idle_pct = 20;
    endtask

    task automatic test_drain_pauses();
        run_random_phase(20, 160, 1'b1);
    endtask

    initial begin
        test_reset();
        test_directed();
        test_full_window();
        test_random_mix();
        test_no_idle();
        test_drain_pauses();

        // drain, then watch a while longer for stray results
        stream_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_acc.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_acc.size()));
        end

        $display("Run covered %0d loads, %0d pushes, %0d clears, %0d unused-code requests",
                 n_loads, n_pushes, n_clears, n_ignored);
        $display("%0d results checked over %0d tap-count settings, %0d mismatches",
                 results_checked, n_settings, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/fc_pkg.sv
design/fc_ram.sv
design/fc_mac.sv
design/fc_seq.sv
design/fir_convolution.sv
design/fc_checker.sv
sim/fir_convolution_tb.sv
